// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros shared by the radix digit converter
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RDC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RDC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/rdc_pkg.sv =====
// ---------------------------------------------------------------------------
// rdc_pkg
// types, constants and the digit-to-character mapping of the radix converter
// ---------------------------------------------------------------------------
package rdc_pkg;

   localparam int NUMBER_W = 31;
   localparam int RADIX_W  = 6;
   localparam int DIGIT_W  = 6;
   localparam int CHAR_W   = 7;

   localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

   localparam logic [CHAR_W-1:0]  CHAR_ZERO = 7'h30;  // '0'
   localparam logic [CHAR_W-1:0]  CHAR_A    = 7'h61;  // 'a'
   localparam logic [DIGIT_W-1:0] DEC_LIMIT = 6'd10;

   typedef struct packed {
      logic [NUMBER_W-1:0] number;
      logic [RADIX_W-1:0]  radix;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] digit_char;
      logic              last;
      logic              error;
   } rsp_type;

   // carry wavefront passed from one digit cell to the next
   typedef struct packed {
      logic valid;
      logic carry;
   } link_type;

   function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if (d < DEC_LIMIT) begin
         c = CHAR_ZERO + CHAR_W'(d);
      end else begin
         c = CHAR_A + CHAR_W'(d - DEC_LIMIT);
      end
      return c;
   endfunction

endpackage

// ===== hdl/radix_digit_converter.sv =====
// ---------------------------------------------------------------------------
// radix_digit_converter
// converts an unsigned integer to ascii digits in a base from 2 to 36
// ---------------------------------------------------------------------------
// usage:
//   req channel carries number and radix; rsp channel returns one beat per
//   digit, most significant first, with last set on the final digit.
//   a radix outside 2..36 returns a single beat with error and last set and
//   digit_char zero. zero converts to the single digit '0'.
//   conversion runs through a row of VALUE_BITS digit cells: the number's
//   bits enter the lowest cell msb first and each cell doubles its digit and
//   adds a carry modulo the radix, the carry moving one cell per cycle.
//   the carry wavefront first crosses the whole row, then the row shifts out
//   toward the top cell in readout, skipping leading zeros.
//   one number is in flight at a time; req_stall is high until its last
//   beat is loaded into the output register.
//   a stalled rsp beat holds in the output register and readout pauses.
//   reset (synchronous, active high) returns to idle with no rsp beat.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module radix_digit_converter #(
   parameter int VALUE_BITS = 31
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rdc_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rdc_pkg::rsp_type rsp_payload
);
   import rdc_pkg::*;

   localparam int CW = $clog2(2 * VALUE_BITS);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CONV = 4'b0010,
      ST_EMIT = 4'b0100,
      ST_ERR  = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] num_ff, num_in;
   logic [RADIX_W-1:0]    radix_ff, radix_in;
   logic                  started_ff, started_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   link_type              link [VALUE_BITS+1];
   logic [DIGIT_W-1:0]    dig [VALUE_BITS+1];

   logic                  req_beat, radix_ok, out_free, cell_clear, cell_shift;
   logic [DIGIT_W-1:0]    top_digit;
   logic                  skip_zero;

   assign req_beat = req_valid && !req_stall;
   assign radix_ok = (req_payload.radix >= RADIX_MIN) && (req_payload.radix <= RADIX_MAX);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign top_digit = dig[VALUE_BITS];
   assign skip_zero = !started_ff && (top_digit == '0) && (cnt_ff > CW'(1));

   // lowest cell takes the number's bits, msb first
   assign link[0].valid = (state_ff == ST_CONV) && (cnt_ff < CW'(VALUE_BITS));
   assign link[0].carry = num_ff[VALUE_BITS-1];
   assign dig[0]        = '0;

   assign cell_clear = req_beat;
   assign cell_shift = (state_ff == ST_EMIT) && (skip_zero || out_free);

   for (genvar i = 0; i < VALUE_BITS; i++) begin : g_cell
      rdc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .radix     (radix_ff),
         .clear     (cell_clear),
         .shift     (cell_shift),
         .link_in   (link[i]),
         .link_out  (link[i+1]),
         .digit_in  (dig[i]),
         .digit_out (dig[i+1])
      );
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      num_in       = num_ff;
      radix_in     = radix_ff;
      started_in   = started_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               num_in     = VALUE_BITS'(req_payload.number);
               radix_in   = req_payload.radix;
               cnt_in     = '0;
               started_in = 1'b0;
               state_in   = radix_ok ? ST_CONV : ST_ERR;
            end
         end
         ST_CONV: begin
            num_in = num_ff << 1;
            cnt_in = cnt_ff + CW'(1);
            // last update lands in the top cell
            if (cnt_ff == CW'(2 * VALUE_BITS - 2)) begin
               cnt_in   = CW'(VALUE_BITS);
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (skip_zero) begin
               cnt_in = cnt_ff - CW'(1);
            end else if (out_free) begin
               cnt_in            = cnt_ff - CW'(1);
               started_in        = 1'b1;
               rsp_valid_in      = 1'b1;
               rsp_in.digit_char = to_ascii(top_digit);
               rsp_in.last       = (cnt_ff == CW'(1));
               rsp_in.error      = 1'b0;
               if (cnt_ff == CW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ERR: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.digit_char = '0;
               rsp_in.last       = 1'b1;
               rsp_in.error      = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff   <= num_in;
      radix_ff <= radix_in;
      rsp_ff   <= rsp_in;
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `RDC_ASSERT_NXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall, "accepted number did not make the block busy")
   `RDC_ASSERT_IMP(a_error_single, clock, reset, rsp_valid && rsp_payload.error, rsp_payload.last && (rsp_payload.digit_char == '0), "error beat not a single zero beat")
   `RDC_ASSERT_IMP(a_more_digits, clock, reset, rsp_valid && !rsp_payload.last, state_ff == ST_EMIT, "digit beat without last outside readout")

endmodule

// ===== hdl/rdc_cell.sv =====
// ---------------------------------------------------------------------------
// rdc_cell
// one digit of the result: doubles itself and adds the incoming carry modulo
// the radix, passes the carry on, and shifts toward the top during readout
// ---------------------------------------------------------------------------
module rdc_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [rdc_pkg::RADIX_W-1:0]  radix,
   input  logic                         clear,
   input  logic                         shift,
   input  rdc_pkg::link_type            link_in,
   output rdc_pkg::link_type            link_out,
   input  logic [rdc_pkg::DIGIT_W-1:0]  digit_in,
   output logic [rdc_pkg::DIGIT_W-1:0]  digit_out
);
   import rdc_pkg::*;

   logic [DIGIT_W-1:0] digit_ff, digit_in_nxt;
   link_type           link_ff, link_in_nxt;
   logic [DIGIT_W:0]   twice;
   logic               over;

   // 2*d + c stays below 2*radix, so one subtract brings it back in range
   assign twice = {digit_ff, link_in.carry};
   assign over  = (twice >= {1'b0, radix});

   always_comb begin
      digit_in_nxt = digit_ff;
      if (clear) begin
         digit_in_nxt = '0;
      end else if (shift) begin
         digit_in_nxt = digit_in;
      end else if (link_in.valid) begin
         digit_in_nxt = over ? DIGIT_W'(twice - {1'b0, radix}) : DIGIT_W'(twice);
      end
   end

   always_comb begin
      link_in_nxt.valid = link_in.valid && !clear && !shift;
      link_in_nxt.carry = over;
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in_nxt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff <= '0;
      end else begin
         link_ff <= link_in_nxt;
      end
   end

   assign link_out  = link_ff;
   assign digit_out = digit_ff;

endmodule
